// ----- rtl/cscan_disk_request_scheduler_defines.svh -----
// Assertion macros for the C-SCAN scheduler checker.
`ifndef CSCAN_DISK_REQUEST_SCHEDULER_DEFINES_SVH
`define CSCAN_DISK_REQUEST_SCHEDULER_DEFINES_SVH

// Clocked assertion, switched off while reset is held.
`define CSCAN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define CSCAN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cscan_pkg.sv -----
// ----------------------------------------------------------------------------
// cscan_pkg
// Types, codes and helpers shared by the C-SCAN scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cscan_pkg;

  localparam int CYL_W    = 8;
  localparam int SUM_W    = 16;
  localparam int MAP_W    = 256;   // every cylinder an 8-bit number can name
  localparam int GRP_W    = 16;    // bits per search group
  localparam int NGRP     = 16;    // MAP_W / GRP_W
  localparam int GIDX_W   = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  typedef logic [CYL_W-1:0]  cyl_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [GIDX_W-1:0] gidx_t;

  typedef enum logic [1:0] {
    FUNC_MARK      = 2'd0,
    FUNC_START_RUN = 2'd1,
    FUNC_SERVE     = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCAN_UPWARD = 1'b0,
    CFG_START_HEAD  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0] func;
    cyl_t       cylinder;
  } in_item_t;

  typedef struct packed {
    cyl_t served_cylinder;
    sum_t movement_total;
    logic none_left;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GROUP,
    S_WORD,
    S_UPDATE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic mark;       // set the pending bit of the item's cylinder
    logic load_run;   // head from start register, clear movement sum
    logic capture;    // register group flags for a serve
    logic group;      // pick the group
    logic word;       // pick the bit in the group
    logic update;     // commit the serve and register the result
  } cmd_t;

  // Index of the lowest set bit of a 16-bit word (zero when none set).
  function automatic gidx_t lowest16(input logic [GRP_W-1:0] v);
    gidx_t idx;
    idx = '0;
    for (int k = GRP_W - 1; k >= 0; k--) begin
      if (v[k]) begin
        idx = gidx_t'(k);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cscan_ctrl.sv -----
// ----------------------------------------------------------------------------
// cscan_ctrl
// Sequencer for the C-SCAN scheduler: decodes items and steps a serve.
// ----------------------------------------------------------------------------
`default_nettype none

module cscan_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [1:0]          func,
  output logic                     busy,
  output logic                     out_valid,
  output cscan_pkg::cmd_t          cmd
);

  cscan_pkg::state_t state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cscan_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = 1'b0;
    case (state_r)
      cscan_pkg::S_IDLE: begin
        if (start) begin
          case (func)
            cscan_pkg::FUNC_MARK:      cmd.mark = 1'b1;
            cscan_pkg::FUNC_START_RUN: cmd.load_run = 1'b1;
            cscan_pkg::FUNC_SERVE: begin
              cmd.capture = 1'b1;
              state_nxt   = cscan_pkg::S_GROUP;
            end
            default: ;
          endcase
        end
      end
      cscan_pkg::S_GROUP: begin
        cmd.group = 1'b1;
        state_nxt = cscan_pkg::S_WORD;
      end
      cscan_pkg::S_WORD: begin
        cmd.word  = 1'b1;
        state_nxt = cscan_pkg::S_UPDATE;
      end
      cscan_pkg::S_UPDATE: begin
        cmd.update    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = cscan_pkg::S_IDLE;
      end
      default: state_nxt = cscan_pkg::S_IDLE;
    endcase
  end

  assign busy      = (state_r != cscan_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/cscan_dpath.sv -----
// ----------------------------------------------------------------------------
// cscan_dpath
// Pending bitmap, head, movement sum and the staged next-request search.
// ----------------------------------------------------------------------------
`default_nettype none

module cscan_dpath #(
  parameter int NUM_CYLINDERS = 256
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire cscan_pkg::cmd_t                      cmd,
  input  wire cscan_pkg::cyl_t                      cylinder,
  input  wire logic                                 cfg_we,
  input  wire logic [cscan_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [cscan_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output cscan_pkg::out_item_t                      out_item
);

  // Only cylinders an 8-bit number can name are ever marked.
  localparam int MAP_DEPTH = (NUM_CYLINDERS < cscan_pkg::MAP_W) ?
                             NUM_CYLINDERS : cscan_pkg::MAP_W;

  logic [MAP_DEPTH-1:0]       map_r, map_nxt;
  cscan_pkg::cyl_t            head_r;
  cscan_pkg::sum_t            sum_r;
  logic                       scan_up_r;
  cscan_pkg::cyl_t            start_head_r;

  logic [cscan_pkg::NGRP-1:0] flag_m_r, flag_f_r;
  cscan_pkg::gidx_t           grp_r;
  logic                       use_m_r;
  logic                       none_r;
  cscan_pkg::cyl_t            pick_r;
  cscan_pkg::out_item_t       out_r;

  logic [cscan_pkg::MAP_W-1:0] map_pad, map_o, mbit;
  cscan_pkg::cyl_t             head_o;
  logic [cscan_pkg::NGRP-1:0]  flag_m, flag_f;
  logic [cscan_pkg::GRP_W-1:0] word;
  cscan_pkg::gidx_t            off;
  cscan_pkg::cyl_t             pick_o, head_dist;
  logic [cscan_pkg::SUM_W:0]   sum_ext;
  cscan_pkg::sum_t             sum_sat;

  // Reverse the map for a downward scan so one lowest-first search serves both.
  always_comb begin
    map_pad = '0;
    map_pad[MAP_DEPTH-1:0] = map_r;
    head_o  = scan_up_r ? head_r : ~head_r;
    for (int i = 0; i < cscan_pkg::MAP_W; i++) begin
      map_o[i] = scan_up_r ? map_pad[i] : map_pad[cscan_pkg::MAP_W-1-i];
      mbit[i]  = map_o[i] & (cscan_pkg::cyl_t'(i) >= head_o);
    end
    for (int g = 0; g < cscan_pkg::NGRP; g++) begin
      flag_m[g] = |mbit[g*cscan_pkg::GRP_W +: cscan_pkg::GRP_W];
      flag_f[g] = |map_o[g*cscan_pkg::GRP_W +: cscan_pkg::GRP_W];
    end
  end

  // Word of the chosen group; mask below the head in the head's own group.
  always_comb begin
    word = map_o[{grp_r, 4'b0000} +: cscan_pkg::GRP_W];
    if (use_m_r && (grp_r == head_o[7:4])) begin
      for (int k = 0; k < cscan_pkg::GRP_W; k++) begin
        if (cscan_pkg::gidx_t'(k) < head_o[3:0]) begin
          word[k] = 1'b0;
        end
      end
    end
    off    = cscan_pkg::lowest16(word);
    pick_o = {grp_r, off};
  end

  always_comb begin
    head_dist = (pick_r >= head_r) ? (pick_r - head_r) : (head_r - pick_r);
    sum_ext   = {1'b0, sum_r} + (cscan_pkg::SUM_W+1)'(head_dist);
    sum_sat   = sum_ext[cscan_pkg::SUM_W] ? '1 : sum_ext[cscan_pkg::SUM_W-1:0];
  end

  always_comb begin
    for (int i = 0; i < MAP_DEPTH; i++) begin
      map_nxt[i] = map_r[i];
      if (cmd.mark && (cylinder == cscan_pkg::cyl_t'(i))) begin
        map_nxt[i] = 1'b1;
      end
      if (cmd.update && !none_r && (pick_r == cscan_pkg::cyl_t'(i))) begin
        map_nxt[i] = 1'b0;
      end
    end
  end

  // Architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r        <= '0;
      head_r       <= '0;
      sum_r        <= '0;
      scan_up_r    <= 1'b1;
      start_head_r <= '0;
    end else begin
      map_r <= map_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          cscan_pkg::CFG_SCAN_UPWARD: scan_up_r    <= cfg_wdata[0];
          cscan_pkg::CFG_START_HEAD:  start_head_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load_run) begin
        head_r <= start_head_r;
        sum_r  <= '0;
      end else if (cmd.update && !none_r) begin
        head_r <= pick_r;
        sum_r  <= sum_sat;
      end
    end
  end

  // Search stages and result register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      flag_m_r <= flag_m;
      flag_f_r <= flag_f;
    end
    if (cmd.group) begin
      use_m_r <= |flag_m_r;
      none_r  <= ~|flag_f_r;
      grp_r   <= (|flag_m_r) ? cscan_pkg::lowest16(flag_m_r)
                             : cscan_pkg::lowest16(flag_f_r);
    end
    if (cmd.word) begin
      pick_r <= scan_up_r ? pick_o : ~pick_o;
    end
    if (cmd.update) begin
      if (none_r) begin
        out_r.served_cylinder <= head_r;
        out_r.movement_total  <= sum_r;
        out_r.none_left       <= 1'b1;
      end else begin
        out_r.served_cylinder <= pick_r;
        out_r.movement_total  <= sum_sat;
        out_r.none_left       <= 1'b0;
      end
    end
  end

  assign out_item = out_r;

endmodule

`default_nettype wire

// ----- rtl/cscan_disk_request_scheduler.sv -----
// ----------------------------------------------------------------------------
// cscan_disk_request_scheduler
// C-SCAN disk request scheduler: pending bitmap and next-request search.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_item and raise start; the item is taken at an edge
//   where start is high and busy is low. func MARK sets a cylinder's pending
//   bit, START_RUN loads the head from the start register and clears the
//   movement sum, SERVE picks the next pending cylinder in C-SCAN order.
//   MARK and START_RUN take effect at the accept edge and give no result. SERVE
//   holds busy while it steps through its search states; its result is then
//   registered and shown on the ports once busy is low, marked by out_valid
//   for exactly one cycle. A new item can be accepted in the cycle the result
//   is shown. The serve steps through a staged search: group flags, group
//   pick, bit pick within the group, then the head/sum update.
//   Config port: cfg_we, cfg_idx, cfg_wdata write scan_upward (index 0) and
//   start_head (index 1); write only while the block is idle.
//   Reset (rst_n low, synchronous) clears the pending map, head and sum and
//   sets scan_upward to 1. The receiver cannot stall out_valid: take it or
//   lose it.
// ----------------------------------------------------------------------------
`default_nettype none

module cscan_disk_request_scheduler #(
  parameter int NUM_CYLINDERS = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              start,
  output logic                                   busy,
  input  wire cscan_pkg::in_item_t               in_item,
  // result channel
  output logic                                   out_valid,
  output cscan_pkg::out_item_t                   out_item,
  // configuration port
  input  wire logic                              cfg_we,
  input  wire logic [cscan_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [cscan_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  cscan_pkg::cmd_t cmd;

  // Controller: decode the item and step the serve sequence.
  cscan_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .func      (in_item.func),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Datapath: hold the bitmap, head and sum, run the search.
  cscan_dpath #(
    .NUM_CYLINDERS (NUM_CYLINDERS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cylinder  (in_item.cylinder),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ----- rtl/cscan_checker.sv -----
// ----------------------------------------------------------------------------
// cscan_checker
// Port-level checks of the C-SCAN scheduler's serve timing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cscan_disk_request_scheduler_defines.svh"

module cscan_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire cscan_pkg::in_item_t  in_item,
  input wire logic                 out_valid
);

  logic serve_acc;
  assign serve_acc = start && !busy && (in_item.func == cscan_pkg::FUNC_SERVE);

  `CSCAN_ASSERT(a_serve_busy, serve_acc |=> busy, "serve accepted but block not busy")
  `CSCAN_ASSERT(a_serve_result, serve_acc |-> ##4 out_valid, "serve result not on time")
  `CSCAN_ASSERT(a_strobe_single, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `CSCAN_ASSERT_ALWAYS(a_result_idle, out_valid |-> !busy, "result shown while still busy")

endmodule

bind cscan_disk_request_scheduler cscan_checker u_cscan_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid)
);

`default_nettype wire
